/* rtl/cbwe_pkg.sv */
package cbwe_pkg;

  localparam int unsigned NumCells = 11;
  localparam int unsigned DataBits = 8;
  localparam int unsigned SlotW    = 6;

  typedef enum logic [0:0] {
    CFG_SLOT_MODE = 1'b0,
    CFG_ACK_LEVEL = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_START = 2'd1,
    KIND_ONE   = 2'd2,
    KIND_ZERO  = 2'd3
  } bit_kind_e;

  typedef struct packed {
    bit_kind_e kind;
    logic      mode;
    logic      eor;
  } cell_t;

  typedef struct packed {
    logic [DataBits-1:0] data_byte;
    logic                last_byte;
  } in_t;

  typedef struct packed {
    logic             line_level;
    logic [SlotW-1:0] slot_count;
    logic             end_of_run;
  } out_t;

  function automatic logic [SlotW-1:0] seg_len(logic mode, bit_kind_e kind, logic phase);
    logic [SlotW-1:0] len;
    len = '0;
    case ({mode, phase})
      2'b00: begin
        case (kind)
          KIND_START: len = 6'd12;
          KIND_ONE:   len = 6'd2;
          KIND_ZERO:  len = 6'd5;
          default:    len = '0;
        endcase
      end
      2'b01: begin
        case (kind)
          KIND_START: len = 6'd3;
          KIND_ONE:   len = 6'd6;
          KIND_ZERO:  len = 6'd3;
          default:    len = '0;
        endcase
      end
      2'b10: begin
        case (kind)
          KIND_START: len = 6'd37;
          KIND_ONE:   len = 6'd6;
          KIND_ZERO:  len = 6'd15;
          default:    len = '0;
        endcase
      end
      default: begin
        case (kind)
          KIND_START: len = 6'd8;
          KIND_ONE:   len = 6'd18;
          KIND_ZERO:  len = 6'd9;
          default:    len = '0;
        endcase
      end
    endcase
    return len;
  endfunction

  function automatic bit_kind_e bit_kind(logic b);
    return b ? KIND_ONE : KIND_ZERO;
  endfunction

endpackage

/* rtl/cec_bit_waveform_encoder.sv */
// An accepted byte is loaded into the bit cells; segments leave through a register.
// One segment per cycle unless stalled; a byte makes 20 segments, 22 opening a frame.
// The next byte is taken as the last bit cell of the row hands over its high segment.
// Reset (rst_ni low, asynchronous): bit cells empty, no segment pending,
// slot_mode and ack_level 0, next byte opens a frame.
module cec_bit_waveform_encoder
  import cbwe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  logic  slot_mode_q, ack_level_q, frame_open_q;
  cell_t cells   [NumCells];
  cell_t next_val[NumCells];
  cell_t load_vec[NumCells];
  logic  advance, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_mode_q <= 1'b0;
      ack_level_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SLOT_MODE: slot_mode_q <= cfg_data_i[0];
        CFG_ACK_LEVEL: ack_level_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !((cells[0].kind == KIND_NONE) ||
                        (advance && (cells[1].kind == KIND_NONE)));
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else if (accept) begin
      frame_open_q <= !in_data_i.last_byte;
    end
  end

  always_comb begin
    for (int k = 0; k < NumCells; k++) begin
      load_vec[k] = '0;
    end
    if (!frame_open_q) begin
      load_vec[0] = '{kind: KIND_START, mode: slot_mode_q, eor: 1'b0};
      for (int j = 0; j < DataBits; j++) begin
        load_vec[j+1] = '{kind: bit_kind(in_data_i.data_byte[DataBits-1-j]),
                          mode: slot_mode_q, eor: 1'b0};
      end
      load_vec[DataBits+1] = '{kind: bit_kind(in_data_i.last_byte),
                               mode: slot_mode_q, eor: 1'b0};
      load_vec[DataBits+2] = '{kind: bit_kind(ack_level_q),
                               mode: slot_mode_q, eor: 1'b1};
    end else begin
      for (int j = 0; j < DataBits; j++) begin
        load_vec[j] = '{kind: bit_kind(in_data_i.data_byte[DataBits-1-j]),
                        mode: slot_mode_q, eor: 1'b0};
      end
      load_vec[DataBits]   = '{kind: bit_kind(in_data_i.last_byte),
                               mode: slot_mode_q, eor: 1'b0};
      load_vec[DataBits+1] = '{kind: bit_kind(ack_level_q),
                               mode: slot_mode_q, eor: 1'b1};
    end
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    if (g == NumCells - 1) begin : g_tail
      assign next_val[g] = '0;
    end else begin : g_mid
      assign next_val[g] = cells[g+1];
    end

    cbwe_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (accept),
      .shift_i    (advance),
      .load_val_i (load_vec[g]),
      .next_val_i (next_val[g]),
      .val_o      (cells[g])
    );
  end

  cbwe_seg_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (cells[0]),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .advance_o   (advance)
  );

endmodule

/* rtl/cbwe_cell.sv */
module cbwe_cell
  import cbwe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  logic  shift_i,
  input  cell_t load_val_i,
  input  cell_t next_val_i,
  output cell_t val_o
);

  cell_t val_d, val_q;

  always_comb begin
    val_d = val_q;
    if (load_i) begin
      val_d = load_val_i;
    end else if (shift_i) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

/* rtl/cbwe_seg_emit.sv */
module cbwe_seg_emit
  import cbwe_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t head_i,
  input  logic  out_stall_i,
  output logic  out_valid_o,
  output out_t  out_data_o,
  output logic  advance_o
);

  logic phase_d, phase_q;
  logic valid_d, valid_q;
  out_t data_d, data_q;
  logic can_load, emit;

  assign can_load  = !valid_q || !out_stall_i;
  assign emit      = can_load && (head_i.kind != KIND_NONE);
  assign advance_o = emit && phase_q;

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    data_d  = data_q;
    if (emit) begin
      phase_d            = !phase_q;
      valid_d            = 1'b1;
      data_d.line_level  = phase_q;
      data_d.slot_count  = seg_len(head_i.mode, head_i.kind, phase_q);
      data_d.end_of_run  = phase_q & head_i.eor;
    end else if (can_load) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* tb/sv/cbwe_segment_checker.sv */
`timescale 1ns / 1ps

module cbwe_segment_checker
  import cbwe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_t        in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_t       out_data_i,
  output int         fail_count_o,
  output int         segments_owed_o
);

  out_t segments_due[$];
  logic slot_mode_q;
  logic ack_level_q;
  logic frame_open_q;
  int   fail_count;

  function automatic logic [SlotW-1:0] slot_len(logic mode, bit_kind_e kind, logic high);
    logic [SlotW-1:0] len;
    len = '0;
    unique case (kind)
      KIND_START: len = high ? (mode ? 6'd8 : 6'd3) : (mode ? 6'd37 : 6'd12);
      KIND_ONE:   len = high ? (mode ? 6'd18 : 6'd6) : (mode ? 6'd6 : 6'd2);
      KIND_ZERO:  len = high ? (mode ? 6'd9 : 6'd3) : (mode ? 6'd15 : 6'd5);
      default:    len = '0;
    endcase
    return len;
  endfunction

  function automatic void push_cell(bit_kind_e kind, logic tail);
    out_t seg;
    seg.line_level = 1'b0;
    seg.slot_count = slot_len(slot_mode_q, kind, 1'b0);
    seg.end_of_run = 1'b0;
    segments_due.push_back(seg);
    seg.line_level = 1'b1;
    seg.slot_count = slot_len(slot_mode_q, kind, 1'b1);
    seg.end_of_run = tail;
    segments_due.push_back(seg);
  endfunction

  function automatic void predict_segments(logic [DataBits-1:0] data_byte, logic last_byte);
    if (!frame_open_q) push_cell(KIND_START, 1'b0);
    for (int i = DataBits - 1; i >= 0; i--) begin
      push_cell(data_byte[i] ? KIND_ONE : KIND_ZERO, 1'b0);
    end
    push_cell(last_byte ? KIND_ONE : KIND_ZERO, 1'b0);
    push_cell(ack_level_q ? KIND_ONE : KIND_ZERO, 1'b1);
    frame_open_q = !last_byte;
  endfunction

  task automatic report(string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      segments_due.delete();
      slot_mode_q  = 1'b0;
      ack_level_q  = 1'b0;
      frame_open_q = 1'b0;
      fail_count   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (segments_due.size() == 0) begin
          report($sformatf("unexpected segment level %0b slots %0d eor %0b",
                           out_data_i.line_level, out_data_i.slot_count,
                           out_data_i.end_of_run));
        end else begin
          want = segments_due.pop_front();
          if (out_data_i.line_level !== want.line_level)
            report($sformatf("line_level expected %0b got %0b",
                             want.line_level, out_data_i.line_level));
          if (out_data_i.slot_count !== want.slot_count)
            report($sformatf("slot_count expected %0d got %0d",
                             want.slot_count, out_data_i.slot_count));
          if (out_data_i.end_of_run !== want.end_of_run)
            report($sformatf("end_of_run expected %0b got %0b",
                             want.end_of_run, out_data_i.end_of_run));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_segments(in_data_i.data_byte, in_data_i.last_byte);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SLOT_MODE) slot_mode_q = cfg_data_i[0];
        else if (cfg_idx_i == CFG_ACK_LEVEL) ack_level_q = cfg_data_i[0];
      end
    end
    fail_count_o    <= fail_count;
    segments_owed_o <= segments_due.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import cbwe_pkg::*;

  localparam int HangLimit = 2000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [0:0] cfg_idx   = '0;
  logic [0:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  int         fail_count;
  int         segments_owed;
  int         idle_cycles = 0;
  bit         no_gaps = 1'b0;

  cec_bit_waveform_encoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  cbwe_segment_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .segments_owed_o(segments_owed)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("cec_bit_waveform_encoder verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int w;
    wait (rst_n);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(logic [7:0] data_byte, logic last_byte);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= data_byte;
    in_data.last_byte <= last_byte;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every segment owed has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (segments_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int flen;
    int pos;
    logic last;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_reg(CFG_SLOT_MODE, 1'b0);
    set_reg(CFG_ACK_LEVEL, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b1);
    drain();
    set_reg(CFG_ACK_LEVEL, 1'b1);
    set_reg(CFG_SLOT_MODE, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    // switch timing in the middle of an open frame
    drain();
    set_reg(CFG_SLOT_MODE, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    drain();
    set_reg(CFG_ACK_LEVEL, 1'b0);
    set_reg(CFG_SLOT_MODE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC3, 1'b1);

    flen = 0;
    pos  = 0;
    for (int p = 0; p < 6; p++) begin
      drain();
      no_gaps = (p == 2);
      set_reg(CFG_SLOT_MODE, (p < 4) ? p[0] : 1'($urandom_range(0, 1)));
      set_reg(CFG_ACK_LEVEL, (p < 4) ? p[1] : 1'($urandom_range(0, 1)));
      for (int n = 0; n < 60; n++) begin
        if (pos >= flen) begin
          flen = $urandom_range(1, 16);
          pos  = 0;
        end
        last = (pos == flen - 1);
        if ($urandom_range(0, 7) == 0) last = 1'($urandom_range(0, 1));
        if (last) pos = flen;
        else pos++;
        send_byte(8'($urandom_range(0, 255)), last);
      end
    end
    no_gaps = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && segments_owed == 0) begin
      $display("cec_bit_waveform_encoder verification clean");
    end else begin
      $display("cec_bit_waveform_encoder verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cbwe_pkg.sv
rtl/cbwe_cell.sv
rtl/cbwe_seg_emit.sv
rtl/cec_bit_waveform_encoder.sv
tb/sv/cbwe_segment_checker.sv
tb/sv/tb.sv
